[design/ics_pkg.sv]
package ics_pkg;

    localparam int CMD_BITS  = 6;
    localparam int DATA_BITS = 14;
    localparam int WAIT_BITS = 16;
    localparam int PULSE_BITS = 5;

    localparam logic [PULSE_BITS-1:0] LAST_CMD_PULSE   = 5'd5;
    localparam logic [PULSE_BITS-1:0] START_PULSE      = 5'd6;
    localparam logic [PULSE_BITS-1:0] FIRST_DATA_PULSE = 5'd7;
    localparam logic [PULSE_BITS-1:0] LAST_DATA_PULSE  = 5'd20;
    localparam logic [PULSE_BITS-1:0] STOP_PULSE       = 5'd21;

    localparam logic [CMD_BITS-1:0] OP_LOAD_CONFIG = 6'b000000;
    localparam logic [CMD_BITS-1:0] OP_LOAD_PROG   = 6'b000010;
    localparam logic [CMD_BITS-1:0] OP_LOAD_DATA   = 6'b000011;
    localparam logic [CMD_BITS-1:0] OP_READ_PROG   = 6'b000100;
    localparam logic [CMD_BITS-1:0] OP_READ_DATA   = 6'b000101;
    localparam logic [CMD_BITS-1:0] OP_INC_ADDR    = 6'b000110;
    localparam logic [CMD_BITS-1:0] OP_RESET_ADDR  = 6'b010110;
    localparam logic [CMD_BITS-1:0] OP_BEGIN_PROG  = 6'b001000;
    localparam logic [CMD_BITS-1:0] OP_END_PROG    = 6'b001110;
    localparam logic [CMD_BITS-1:0] OP_ERASE_PROG  = 6'b001001;
    localparam logic [CMD_BITS-1:0] OP_ERASE_DATA  = 6'b001011;

    localparam logic [1:0] REG_PROG_WAIT_DATA = 2'd0;
    localparam logic [1:0] REG_PROG_WAIT_CODE = 2'd1;
    localparam logic [1:0] REG_ERASE_WAIT     = 2'd2;
    localparam logic [1:0] REG_DISCHARGE_WAIT = 2'd3;

    localparam logic [WAIT_BITS-1:0] RST_PROG_WAIT_DATA = 16'd120;
    localparam logic [WAIT_BITS-1:0] RST_PROG_WAIT_CODE = 16'd80;
    localparam logic [WAIT_BITS-1:0] RST_ERASE_WAIT     = 16'd200;
    localparam logic [7:0]           RST_DISCHARGE_WAIT = 8'd100;

    typedef enum logic [1:0] {
        KIND_PLAIN,
        KIND_LOAD,
        KIND_READ
    } cmd_kind_t;

    typedef struct packed {
        logic [CMD_BITS-1:0]  op;
        cmd_kind_t            kind;
        logic [DATA_BITS-1:0] word;
        logic [DATA_BITS-1:0] tgt;
        logic [WAIT_BITS-1:0] wait_amount;
        logic                 wait_short;
    } cmd_t;

endpackage

[design/icsp_command_shifter.sv]
// The first pulse of a command is written into the queue when the request is taken, and then into the output register.
// One pulse per cycle while the output is not stalled; load and read commands send 22 pulses, others 6.
// The serializer's pulse counter sets that rate, and a two-entry queue decouples the decoder.
// Unknown command codes are consumed without entering the queue and produce no pulses.
// Reset clears the queue, the output valid flag, the pulse counter and the pending-data flag, and restores the waits.
module icsp_command_shifter
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [ics_pkg::CMD_BITS-1:0]   op,
    input  logic [ics_pkg::DATA_BITS-1:0]  data_word,
    input  logic [ics_pkg::DATA_BITS-1:0]  target_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           pin_level,
    output logic                           pin_driven,
    output logic                           last_pulse,
    output logic [ics_pkg::DATA_BITS-1:0]  read_word,
    output logic [ics_pkg::WAIT_BITS-1:0]  wait_amount,
    output logic                           wait_short,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [1:0]                     cfg_index,
    input  logic [15:0]                    cfg_data
);

    logic          q_full;
    logic          push;
    logic          pop;
    logic          q_valid;
    ics_pkg::cmd_t push_cmd;
    ics_pkg::cmd_t q_cmd;

    assign cfg_ready = 1'b1;
    assign in_stall  = q_full;

    ics_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .q_full      (q_full),
        .op          (op),
        .data_word   (data_word),
        .target_data (target_data),
        .cfg_write   (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .push        (push),
        .push_cmd    (push_cmd)
    );

    ics_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .full     (q_full),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd)
    );

    ics_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_cmd       (q_cmd),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pin_level   (pin_level),
        .pin_driven  (pin_driven),
        .last_pulse  (last_pulse),
        .read_word   (read_word),
        .wait_amount (wait_amount),
        .wait_short  (wait_short)
    );

endmodule

[design/ics_front.sv]
module ics_front
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           q_full,
    input  logic [ics_pkg::CMD_BITS-1:0]   op,
    input  logic [ics_pkg::DATA_BITS-1:0]  data_word,
    input  logic [ics_pkg::DATA_BITS-1:0]  target_data,
    input  logic                           cfg_write,
    input  logic [1:0]                     cfg_index,
    input  logic [15:0]                    cfg_data,
    output logic                           push,
    output ics_pkg::cmd_t                  push_cmd
);

    logic [15:0] prog_wait_data_reg;
    logic [15:0] prog_wait_code_reg;
    logic [15:0] erase_wait_reg;
    logic [7:0]  discharge_wait_reg;
    logic        pending_reg;
    logic        pending_next;
    logic        known;
    logic        accept;

    assign accept = in_valid && !q_full;
    assign push   = accept && known;

    always_comb
    begin
        known                = 1'b1;
        pending_next         = pending_reg;
        push_cmd.op          = op;
        push_cmd.kind        = ics_pkg::KIND_PLAIN;
        push_cmd.word        = data_word;
        push_cmd.tgt         = target_data;
        push_cmd.wait_amount = '0;
        push_cmd.wait_short  = 1'b0;
        unique case (op)
            ics_pkg::OP_LOAD_CONFIG, ics_pkg::OP_LOAD_PROG:
            begin
                push_cmd.kind = ics_pkg::KIND_LOAD;
                pending_next  = 1'b0;
            end
            ics_pkg::OP_LOAD_DATA:
            begin
                push_cmd.kind = ics_pkg::KIND_LOAD;
                pending_next  = 1'b1;
            end
            ics_pkg::OP_READ_PROG, ics_pkg::OP_READ_DATA:
            begin
                push_cmd.kind = ics_pkg::KIND_READ;
            end
            ics_pkg::OP_INC_ADDR, ics_pkg::OP_RESET_ADDR:
            begin
                push_cmd.kind = ics_pkg::KIND_PLAIN;
            end
            ics_pkg::OP_BEGIN_PROG:
            begin
                push_cmd.wait_amount = pending_reg ? prog_wait_data_reg : prog_wait_code_reg;
                pending_next         = 1'b0;
            end
            ics_pkg::OP_END_PROG:
            begin
                push_cmd.wait_amount = {8'd0, discharge_wait_reg};
                push_cmd.wait_short  = 1'b1;
            end
            ics_pkg::OP_ERASE_PROG, ics_pkg::OP_ERASE_DATA:
            begin
                push_cmd.wait_amount = erase_wait_reg;
            end
            default:
            begin
                known = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prog_wait_data_reg <= ics_pkg::RST_PROG_WAIT_DATA;
            prog_wait_code_reg <= ics_pkg::RST_PROG_WAIT_CODE;
            erase_wait_reg     <= ics_pkg::RST_ERASE_WAIT;
            discharge_wait_reg <= ics_pkg::RST_DISCHARGE_WAIT;
            pending_reg        <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                pending_reg <= pending_next;
            end
            if (cfg_write)
            begin
                unique case (cfg_index)
                    ics_pkg::REG_PROG_WAIT_DATA: prog_wait_data_reg <= cfg_data;
                    ics_pkg::REG_PROG_WAIT_CODE: prog_wait_code_reg <= cfg_data;
                    ics_pkg::REG_ERASE_WAIT:     erase_wait_reg     <= cfg_data;
                    ics_pkg::REG_DISCHARGE_WAIT: discharge_wait_reg <= cfg_data[7:0];
                    default:                     ;
                endcase
            end
        end
    end

endmodule

[design/ics_queue.sv]
module ics_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  ics_pkg::cmd_t push_cmd,
    input  logic          pop,
    output logic          full,
    output logic          q_valid,
    output ics_pkg::cmd_t q_cmd
);

    ics_pkg::cmd_t entry_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;

    assign full    = (count_reg == 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_cmd   = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

[design/ics_back.sv]
module ics_back
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_valid,
    input  ics_pkg::cmd_t                  q_cmd,
    output logic                           pop,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           pin_level,
    output logic                           pin_driven,
    output logic                           last_pulse,
    output logic [ics_pkg::DATA_BITS-1:0]  read_word,
    output logic [ics_pkg::WAIT_BITS-1:0]  wait_amount,
    output logic                           wait_short
);

    logic [ics_pkg::PULSE_BITS-1:0] cnt_reg;
    logic [ics_pkg::PULSE_BITS-1:0] data_idx;
    logic [ics_pkg::CMD_BITS-1:0]   op_shift;
    logic [ics_pkg::DATA_BITS-1:0]  word_shift;
    logic                           out_valid_reg;
    logic                           level_reg;
    logic                           driven_reg;
    logic                           last_reg;
    logic [ics_pkg::DATA_BITS-1:0]  read_word_reg;
    logic [ics_pkg::WAIT_BITS-1:0]  wait_reg;
    logic                           short_reg;
    logic                           can_load;
    logic                           step;
    logic                           in_cmd;
    logic                           in_data;
    logic                           level_next;
    logic                           driven_next;
    logic                           last_next;

    assign can_load   = !out_valid_reg || !out_stall;
    assign step       = can_load && q_valid;
    assign pop        = step && last_next;

    assign in_cmd     = (cnt_reg <= ics_pkg::LAST_CMD_PULSE);
    assign in_data    = (cnt_reg >= ics_pkg::FIRST_DATA_PULSE)
                        && (cnt_reg <= ics_pkg::LAST_DATA_PULSE);
    assign data_idx   = cnt_reg - ics_pkg::FIRST_DATA_PULSE;
    assign op_shift   = q_cmd.op >> cnt_reg[2:0];
    assign word_shift = q_cmd.word >> data_idx[3:0];

    always_comb
    begin
        if (q_cmd.kind == ics_pkg::KIND_PLAIN)
        begin
            last_next = (cnt_reg == ics_pkg::LAST_CMD_PULSE);
        end
        else
        begin
            last_next = (cnt_reg == ics_pkg::STOP_PULSE);
        end
        driven_next = in_cmd || (q_cmd.kind == ics_pkg::KIND_LOAD);
        priority if (in_cmd)
        begin
            level_next = op_shift[0];
        end
        else if (in_data && q_cmd.kind == ics_pkg::KIND_LOAD)
        begin
            level_next = word_shift[0];
        end
        else
        begin
            level_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            level_reg     <= level_next;
            driven_reg    <= driven_next;
            read_word_reg <= (last_next && q_cmd.kind == ics_pkg::KIND_READ) ? q_cmd.tgt : '0;
            wait_reg      <= last_next ? q_cmd.wait_amount : '0;
            short_reg     <= last_next && q_cmd.wait_short;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            last_reg      <= 1'b0;
        end
        else if (can_load)
        begin
            out_valid_reg <= q_valid;
            if (step)
            begin
                last_reg <= last_next;
                cnt_reg  <= last_next ? '0 : cnt_reg + ics_pkg::PULSE_BITS'(1);
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign pin_level   = level_reg;
    assign pin_driven  = driven_reg;
    assign last_pulse  = last_reg;
    assign read_word   = read_word_reg;
    assign wait_amount = wait_reg;
    assign wait_short  = short_reg;

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= ics_pkg::STOP_PULSE)
        else $error("pulse counter out of range");

    a_cnt_restart: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> cnt_reg == '0)
        else $error("pulse counter did not restart after the final pulse");

    a_tail_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !last_reg |-> wait_reg == '0 && read_word_reg == '0 && !short_reg)
        else $error("wait or read data on a pulse that is not the final one");

    a_released_low: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !driven_reg |-> !level_reg)
        else $error("level driven while the pin is released");

endmodule
